### sv/aoma_pkg.sv
// Shared types and constants for the accelerometer orientation / moving-average block.
// Used by aoma_regs, aoma_window, aoma_div and the top level. No dependencies.
package aoma_pkg;

    localparam int AXES    = 3;
    localparam int SMP_W   = 8;
    localparam int OFS_W   = 9;
    localparam int ENT_W   = 10;
    localparam int ACC_W   = 18;
    localparam int MSK_W   = 4;
    localparam int SCL_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;
    localparam int IN_W    = AXES * SMP_W;
    localparam int OUT_W   = ((AXES * ACC_W + 7) / 8) * 8;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam int MSK_NEG_X = 0;
    localparam int MSK_NEG_Y = 1;
    localparam int MSK_NEG_Z = 2;
    localparam int MSK_SWAP  = 3;

    localparam logic [SCL_W-1:0] SCALE_RST = 8'd18;

    typedef enum logic [2:0] {
        REG_ORIENT = 3'd0,
        REG_OFS_X  = 3'd1,
        REG_OFS_Y  = 3'd2,
        REG_OFS_Z  = 3'd3,
        REG_SCALE  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic        [MSK_W-1:0] orient_mask;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic signed [OFS_W-1:0] offset_z;
        logic        [SCL_W-1:0] scale_mg;
    } cfg_t;

endpackage

### sv/accel_orient_moving_average_top.sv
// Top level: orientation/offset correction, window update, averaging, scaling, output.
// Depends on aoma_pkg, aoma_regs, aoma_window, aoma_div.
//
// Usage:
//   s_tdata carries one raw three-axis sample per beat (x, y, z, 8 bits signed each).
//   m_tdata carries one averaged, scaled milli-g result (x, y, z, 18 bits signed each).
//   A result beat is produced only when some axis differs from the last one sent.
//   The APB port holds orient_mask, offset_x/y/z and scale_mg at byte addresses 0..16;
//   write it only while the block is idle.
// Operation:
//   An accepted sample goes through the window write-back and the divider load, SUM_W
//   bit-serial divider steps, a hand-off, the scale multiply and the output register load.
//   One sample is processed at a time. s_tready rises once the previous result has reached
//   the output register, or once no beat is due for it, so the next sample is taken while
//   a result waits.
//   If the receiver stalls with a result pending and a new differing result is ready,
//   the block holds it, and s_tready stays low, until the output register frees.
// Reset: fill count, running sums, last reported values and the handshake clear;
//   registers return to their reset values. Window entries need no clearing.
module accel_orient_moving_average_top #(
    parameter int WINDOW_LEN = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: sample_x[7:0], sample_y[15:8], sample_z[23:16]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [aoma_pkg::IN_W-1:0]    s_tdata,
    // m_tdata: accel_x[17:0], accel_y[35:18], accel_z[53:36], zero pad[55:54]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [aoma_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aoma_pkg::ADDR_W-1:0]  paddr,
    input  logic [aoma_pkg::APB_W-1:0]   pwdata,
    output logic [aoma_pkg::APB_W-1:0]   prdata,
    output logic                         pready
);
    import aoma_pkg::*;

    localparam int SUM_W = ENT_W + $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WIN  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg;

    logic                    s_accept;
    logic signed [ENT_W-1:0] ext [AXES];
    logic signed [ENT_W-1:0] adj [AXES];
    logic signed [ENT_W-1:0] corr [AXES];
    logic signed [ENT_W-1:0] ofs [AXES];
    logic [AXES-1:0]         neg;

    logic                    win_done;
    logic signed [SUM_W-1:0] win_sum [AXES];
    logic [CNT_W-1:0]        win_count;
    logic                    div_done;
    logic signed [ENT_W-1:0] quot [AXES];

    logic signed [ACC_W-1:0] scale_ext;
    logic signed [ACC_W-1:0] prod_reg [AXES];
    logic signed [ACC_W-1:0] last_reg [AXES];
    logic signed [ACC_W-1:0] out_reg [AXES];
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    differ;
    logic                    out_load;

    aoma_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    assign ofs[AX_X] = ENT_W'(cfg.offset_x);
    assign ofs[AX_Y] = ENT_W'(cfg.offset_y);
    assign ofs[AX_Z] = ENT_W'(cfg.offset_z);
    assign neg[AX_X] = cfg.orient_mask[MSK_NEG_X];
    assign neg[AX_Y] = cfg.orient_mask[MSK_NEG_Y];
    assign neg[AX_Z] = cfg.orient_mask[MSK_NEG_Z];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            ext[a] = ENT_W'($signed(s_tdata[a*SMP_W +: SMP_W]));
            adj[a] = (neg[a] ? -ext[a] : ext[a]) + ofs[a];
        end
        if (cfg.orient_mask[MSK_SWAP]) begin
            corr[AX_X] = adj[AX_Y];
            corr[AX_Y] = adj[AX_X];
        end else begin
            corr[AX_X] = adj[AX_X];
            corr[AX_Y] = adj[AX_Y];
        end
        corr[AX_Z] = adj[AX_Z];
    end

    aoma_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .corr    (corr),
        .done    (win_done),
        .sum     (win_sum),
        .count   (win_count)
    );

    aoma_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (win_done),
        .sum     (win_sum),
        .divisor (win_count),
        .done    (div_done),
        .quot    (quot)
    );

    assign scale_ext = $signed(ACC_W'({1'b0, cfg.scale_mg}));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            for (int a = 0; a < AXES; a++) begin
                prod_reg[a] <= ACC_W'(quot[a]) * scale_ext;
            end
        end
    end

    assign differ = (prod_reg[AX_X] != last_reg[AX_X]) ||
                    (prod_reg[AX_Y] != last_reg[AX_Y]) ||
                    (prod_reg[AX_Z] != last_reg[AX_Z]);
    assign out_load = (state_reg == ST_OUT) && differ && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_WIN;
            ST_WIN:  if (win_done) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  if (!differ || out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                last_reg[a] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (out_load) begin
                for (int a = 0; a < AXES; a++) begin
                    last_reg[a] <= prod_reg[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int a = 0; a < AXES; a++) begin
                out_reg[a] <= prod_reg[a];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-AXES*ACC_W){1'b0}}, out_reg[AX_Z], out_reg[AX_Y], out_reg[AX_X]};

    a_accept_to_win: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_WIN))
        else $error("accepted sample did not start the window update");

    a_win_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        win_done |-> (state_reg == ST_WIN))
        else $error("window update finished outside its state");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_load_changes_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tvalid_reg && (out_reg[AX_X] == last_reg[AX_X])
                      && (out_reg[AX_Y] == last_reg[AX_Y])
                      && (out_reg[AX_Z] == last_reg[AX_Z])))
        else $error("output beat and last reported values disagree");

endmodule

### sv/aoma_regs.sv
// APB configuration registers: orientation mask, per-axis offsets, scale.
// Depends on aoma_pkg.
module aoma_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aoma_pkg::ADDR_W-1:0]  paddr,
    input  logic [aoma_pkg::APB_W-1:0]   pwdata,
    output logic [aoma_pkg::APB_W-1:0]   prdata,
    output logic                         pready,
    output aoma_pkg::cfg_t               cfg
);
    import aoma_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ORIENT: cfg_next.orient_mask = pwdata[MSK_W-1:0];
                REG_OFS_X:  cfg_next.offset_x    = $signed(pwdata[OFS_W-1:0]);
                REG_OFS_Y:  cfg_next.offset_y    = $signed(pwdata[OFS_W-1:0]);
                REG_OFS_Z:  cfg_next.offset_z    = $signed(pwdata[OFS_W-1:0]);
                REG_SCALE:  cfg_next.scale_mg    = pwdata[SCL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ORIENT: prdata = {{(APB_W-MSK_W){1'b0}}, cfg_reg.orient_mask};
            REG_OFS_X:  prdata = {{(APB_W-OFS_W){1'b0}}, cfg_reg.offset_x};
            REG_OFS_Y:  prdata = {{(APB_W-OFS_W){1'b0}}, cfg_reg.offset_y};
            REG_OFS_Z:  prdata = {{(APB_W-OFS_W){1'b0}}, cfg_reg.offset_z};
            REG_SCALE:  prdata = {{(APB_W-SCL_W){1'b0}}, cfg_reg.scale_mg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.orient_mask <= '0;
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
            cfg_reg.offset_z    <= '0;
            cfg_reg.scale_mg    <= SCALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/aoma_window.sv
// Sample window memory with per-axis running sums (read old entry, update, write back).
// Depends on aoma_pkg.
module aoma_window #(
    parameter  int WINDOW_LEN = 7,
    localparam int SUM_W = aoma_pkg::ENT_W + $clog2(WINDOW_LEN),
    localparam int CNT_W = $clog2(WINDOW_LEN + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [aoma_pkg::ENT_W-1:0] corr [aoma_pkg::AXES],
    output logic                              done,
    output logic signed [SUM_W-1:0]           sum [aoma_pkg::AXES],
    output logic        [CNT_W-1:0]           count
);
    import aoma_pkg::*;

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MEM_W = AXES * ENT_W;

    logic [MEM_W-1:0] mem [WINDOW_LEN];
    logic [MEM_W-1:0] rd_data_reg;
    logic [MEM_W-1:0] new_reg;

    logic              phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    logic              full;
    logic [MEM_W-1:0]  new_word;

    assign full = (count_reg == CNT_W'(WINDOW_LEN));

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            new_word[a*ENT_W +: ENT_W] = corr[a];
        end
    end

    always_comb begin
        phase_next = start;
        done_next  = phase_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        for (int a = 0; a < AXES; a++) begin
            sum_next[a] = sum_reg[a];
        end
        if (phase_reg) begin
            for (int a = 0; a < AXES; a++) begin
                sum_next[a] = sum_reg[a]
                            + SUM_W'($signed(new_reg[a*ENT_W +: ENT_W]))
                            - (full ? SUM_W'($signed(rd_data_reg[a*ENT_W +: ENT_W]))
                                    : SUM_W'(0));
            end
            ptr_next = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + 1'b1;
            if (!full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            ptr_reg   <= '0;
            count_reg <= '0;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= sum_next[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rd_data_reg <= mem[ptr_reg];
            new_reg     <= new_word;
        end
        if (phase_reg) begin
            mem[ptr_reg] <= new_reg;
        end
    end

    assign done  = done_reg;
    assign count = count_reg;
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            sum[a] = sum_reg[a];
        end
    end

endmodule

### sv/aoma_div.sv
// Three-lane bit-serial signed divider: window sum / fill count, truncating toward zero.
// Depends on aoma_pkg.
module aoma_div #(
    parameter  int WINDOW_LEN = 7,
    localparam int SUM_W = aoma_pkg::ENT_W + $clog2(WINDOW_LEN),
    localparam int CNT_W = $clog2(WINDOW_LEN + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           sum [aoma_pkg::AXES],
    input  logic        [CNT_W-1:0]           divisor,
    output logic                              done,
    output logic signed [aoma_pkg::ENT_W-1:0] quot [aoma_pkg::AXES]
);
    import aoma_pkg::*;

    localparam int IT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] mag_reg [AXES];
    logic [SUM_W-1:0] mag_next [AXES];
    logic [CNT_W-1:0] rem_reg [AXES];
    logic [CNT_W-1:0] rem_next [AXES];
    logic [AXES-1:0]  neg_reg;
    logic [CNT_W-1:0] div_reg;
    logic [IT_W-1:0]  it_reg, it_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial [AXES];
    logic [AXES-1:0]  ge;
    logic [SUM_W-1:0] q_full [AXES];

    always_comb begin
        busy_next = busy_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            trial[a]    = {rem_reg[a], mag_reg[a][SUM_W-1]};
            ge[a]       = (trial[a] >= {1'b0, div_reg});
            rem_next[a] = ge[a] ? CNT_W'(trial[a] - {1'b0, div_reg}) : CNT_W'(trial[a]);
            mag_next[a] = {mag_reg[a][SUM_W-2:0], ge[a]};
        end
        if (busy_reg) begin
            it_next = it_reg - 1'b1;
            if (it_reg == IT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start) begin
            busy_next = 1'b1;
            it_next   = IT_W'(SUM_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            for (int a = 0; a < AXES; a++) begin
                neg_reg[a] <= sum[a][SUM_W-1];
                mag_reg[a] <= sum[a][SUM_W-1] ? SUM_W'(-sum[a]) : SUM_W'(sum[a]);
                rem_reg[a] <= '0;
            end
        end else if (busy_reg) begin
            for (int a = 0; a < AXES; a++) begin
                mag_reg[a] <= mag_next[a];
                rem_reg[a] <= rem_next[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            q_full[a] = neg_reg[a] ? -mag_reg[a] : mag_reg[a];
            quot[a]   = $signed(q_full[a][ENT_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

### dv/tb_accel_orient_moving_average_top.sv
`timescale 1ns / 100ps
// Testbench for accel_orient_moving_average_top: streams raw three-axis samples, predicts
// the averaged milli-g beats in-line and checks every result beat against that prediction.
// Depends on aoma_pkg and the RTL of the block.
module tb_accel_orient_moving_average_top;
    import aoma_pkg::*;

    localparam int WIN        = 7;
    localparam int DRAIN      = 40;
    localparam int HOLD_LEN   = 400;
    localparam int WDOG_LIMIT = 4000;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 95;

    typedef struct packed {
        logic signed [SMP_W-1:0] z, y, x;
    } sample_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] z, y, x;
    } accel_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    // register shadow
    int orient = 0;
    int ofs[AXES] = '{0, 0, 0};
    int scale = int'(SCALE_RST);

    // filter state
    int win_val[AXES][WIN];
    int fill_cnt = 0;
    int wr_pos = 0;
    int last_mg[AXES] = '{0, 0, 0};

    sample_t raw_q[$];
    accel_t  mg_q[$];

    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    bit     hold_req     = 1'b0;
    bit     hold_done    = 1'b0;
    int     hold_cnt     = 0;
    bit     s_took       = 1'b0;
    int     quiet_cyc    = 0;
    int     err_cnt      = 0;
    accel_t got_mg;
    accel_t want_mg;
    accel_t new_mg;

    accel_orient_moving_average_top #(
        .WINDOW_LEN(WIN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 aclk = ~aclk;

    // Correct, window, average and scale one sample; returns 1 when a beat is due.
    function automatic bit filter_sample(input sample_t s, output accel_t mg);
        int v[AXES];
        int prod[AXES];
        int sum;
        int t;
        bit changed;
        v[AX_X] = int'(s.x);
        v[AX_Y] = int'(s.y);
        v[AX_Z] = int'(s.z);
        for (int a = 0; a < AXES; a++) begin
            if (orient[MSK_NEG_X + a]) begin
                v[a] = -v[a];
            end
            v[a] = v[a] + ofs[a];
        end
        if (orient[MSK_SWAP]) begin
            t = v[AX_X];
            v[AX_X] = v[AX_Y];
            v[AX_Y] = t;
        end
        for (int a = 0; a < AXES; a++) begin
            win_val[a][wr_pos] = v[a];
        end
        wr_pos = (wr_pos + 1) % WIN;
        if (fill_cnt < WIN) begin
            fill_cnt++;
        end
        changed = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            sum = 0;
            for (int i = 0; i < fill_cnt; i++) begin
                sum += win_val[a][i];
            end
            prod[a] = (sum / fill_cnt) * scale;
            if (prod[a] != last_mg[a]) begin
                changed = 1'b1;
            end
        end
        mg.x = ACC_W'(prod[AX_X]);
        mg.y = ACC_W'(prod[AX_Y]);
        mg.z = ACC_W'(prod[AX_Z]);
        if (changed) begin
            last_mg = prod;
        end
        return changed;
    endfunction

    function automatic sample_t mk_sample(input int x, input int y, input int z);
        sample_t s;
        s.x = x[SMP_W-1:0];
        s.y = y[SMP_W-1:0];
        s.z = z[SMP_W-1:0];
        return s;
    endfunction

    task automatic push_samples(input int x, input int y, input int z, input int n);
        repeat (n) raw_q.push_back(mk_sample(x, y, z));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIENT: orient = value & 32'hF;
            REG_OFS_X:  ofs[AX_X] = int'(signed'(value[OFS_W-1:0]));
            REG_OFS_Y:  ofs[AX_Y] = int'(signed'(value[OFS_W-1:0]));
            REG_OFS_Z:  ofs[AX_Z] = int'(signed'(value[OFS_W-1:0]));
            REG_SCALE:  scale = value & 32'hFF;
            default: ;
        endcase
    endtask

    // Waits until all samples are taken, all beats have arrived and the pipe is empty.
    task automatic drain_block();
        do @(posedge aclk); while (raw_q.size() != 0 || s_tvalid);
        while (mg_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic int pick_offset();
        case ($urandom_range(3))
            0: return -256;
            1: return 255;
            default: return int'($urandom_range(511)) - 256;
        endcase
    endfunction

    function automatic int pick_scale();
        case ($urandom_range(3))
            0: return 1;
            1: return 255;
            default: return int'($urandom_range(255, 1));
        endcase
    endfunction

    task automatic random_config();
        cfg_write(REG_ORIENT, int'($urandom_range(15)));
        cfg_write(REG_OFS_X, pick_offset());
        cfg_write(REG_OFS_Y, pick_offset());
        cfg_write(REG_OFS_Z, pick_offset());
        cfg_write(REG_SCALE, pick_scale());
        if ($urandom_range(3) == 0) begin
            cfg_write(3'($urandom_range(7, 5)), int'($urandom));
        end
    endtask

    // Mostly fresh samples, with runs of repeats so the output settles and goes quiet.
    task automatic random_samples(input int n);
        sample_t s;
        int run;
        run = 0;
        s = '0;
        for (int i = 0; i < n; i++) begin
            if (run > 0) begin
                run--;
            end else begin
                s = sample_t'(IN_W'($urandom));
                if ($urandom_range(99) < 12) begin
                    run = $urandom_range(10, 6);
                end
            end
            raw_q.push_back(s);
        end
    endtask

    // sample driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (raw_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= raw_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_LEN - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            if (!hold_req) begin
                hold_done <= 1'b0;
                hold_cnt  <= 0;
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took    <= 1'b0;
            quiet_cyc <= 0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got_mg = accel_t'(m_tdata[AXES*ACC_W-1:0]);
                if (mg_q.size() == 0) begin
                    if (err_cnt < 10) begin
                        $display("unexpected result beat: x=%0d y=%0d z=%0d",
                                 got_mg.x, got_mg.y, got_mg.z);
                    end
                    err_cnt++;
                end else begin
                    want_mg = mg_q.pop_front();
                    if (got_mg.x !== want_mg.x || got_mg.y !== want_mg.y
                            || got_mg.z !== want_mg.z) begin
                        if (err_cnt < 10) begin
                            $display({"accel mismatch: exp x=%0d y=%0d z=%0d, ",
                                      "got x=%0d y=%0d z=%0d"},
                                     want_mg.x, want_mg.y, want_mg.z,
                                     got_mg.x, got_mg.y, got_mg.z);
                        end
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (filter_sample(sample_t'(s_tdata), new_mg)) begin
                    mg_q.push_back(new_mg);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cyc <= 0;
            end else begin
                quiet_cyc <= quiet_cyc + 1;
            end
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero start, field extremes, settle into an unchanged output
        push_samples(0, 0, 0, 1);
        push_samples(127, -128, 1, 1);
        push_samples(-128, 127, -1, 1);
        push_samples(-1, 0, 127, 1);
        push_samples(5, -7, 3, 8);
        drain_block();

        // full negate and swap with extreme offsets: corrected values hit +/-383
        cfg_write(REG_ORIENT, (1 << MSK_NEG_X) | (1 << MSK_NEG_Y) | (1 << MSK_NEG_Z)
                              | (1 << MSK_SWAP));
        cfg_write(REG_OFS_X, 255);
        cfg_write(REG_OFS_Y, -256);
        cfg_write(REG_OFS_Z, 255);
        cfg_write(REG_SCALE, 255);
        push_samples(-128, 127, -128, 4);
        push_samples(127, -128, 127, 3);
        drain_block();

        // zero scale, swap only, writes to unmapped addresses
        cfg_write(REG_ORIENT, 1 << MSK_SWAP);
        cfg_write(REG_OFS_X, 0);
        cfg_write(REG_OFS_Y, 0);
        cfg_write(REG_OFS_Z, 0);
        cfg_write(REG_SCALE, 0);
        for (int i = 5; i < 8; i++) begin
            cfg_write(3'(i), int'($urandom));
        end
        push_samples(3, 4, 5, 2);
        drain_block();

        for (int p = 0; p < PHASES; p++) begin
            random_config();
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 77;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
                default: begin
                    tx_idle_pct  = 17;
                    rx_stall_pct = 17;
                end
            endcase
            random_samples(PHASE_LEN);
            if (p == 4) begin
                hold_req = 1'b1;
                wait (hold_done);
                hold_req = 1'b0;
            end
            drain_block();
        end

        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
sv/aoma_pkg.sv
sv/aoma_regs.sv
sv/aoma_window.sv
sv/aoma_div.sv
sv/accel_orient_moving_average_top.sv
dv/tb_accel_orient_moving_average_top.sv
